/* hdl/vtgd_pkg.sv */
package vtgd_pkg;

    // default vertex limit per geometry
    localparam int MAX_VERTICES_DEF = 65536;

    // results held per accepted byte and depth of the front-to-back queue
    localparam int N_SLOTS = 3;
    localparam int Q_DEPTH = 2;

    // varint limits: bytes that still land in the low 32 bits, bytes allowed
    localparam logic [3:0] VARINT_KEEP    = 4'd5;
    localparam logic [3:0] VARINT_MAX_LEN = 4'd10;

    // command ids
    localparam logic [2:0] CMD_MOVE_TO    = 3'd1;
    localparam logic [2:0] CMD_LINE_TO    = 3'd2;
    localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

    typedef enum logic [1:0] {
        KIND_VERTEX    = 2'd0,
        KIND_PART_END  = 2'd1,
        KIND_DONE      = 2'd2,
        KIND_MALFORMED = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_CMD = 3'b001,
        PH_DX  = 3'b010,
        PH_DY  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_geometry;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        vertex_index;
        logic [15:0]        part_index;
        logic               last_of_run;
    } t_out;

    // all results caused by one byte, oldest in slot 0
    typedef struct packed {
        logic [1:0]               cnt;
        t_out [N_SLOTS-1:0]       res;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [31:0] unzig(input logic [31:0] v);
        return (v >> 1) ^ {32{v[0]}};
    endfunction

    function automatic t_out make_res(input t_kind k, input logic [31:0] x,
                                      input logic [31:0] y, input logic [15:0] vi,
                                      input logic [15:0] pi);
        t_out r;
        r.kind         = k;
        r.x            = x;
        r.y            = y;
        r.vertex_index = vi;
        r.part_index   = pi;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

/* hdl/vtgd_front.sv */
module vtgd_front #(
    parameter int MAX_VERTICES = vtgd_pkg::MAX_VERTICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  vtgd_pkg::t_in     i_data,
    output logic              o_push,
    output vtgd_pkg::t_bundle o_bundle
);
    import vtgd_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MAX_V = CW'(MAX_VERTICES);

    function automatic logic [15:0] idx16(input logic [CW-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[15:0];
    endfunction

    logic [31:0]   r_accum, n_accum;
    logic [3:0]    r_len, n_len;
    t_phase        r_phase, n_phase;
    logic [28:0]   r_pairs, n_pairs;
    logic [31:0]   r_pdx, n_pdx;
    logic [31:0]   r_cx, n_cx, r_cy, n_cy;
    logic [31:0]   r_rfx, n_rfx, r_rfy, n_rfy;
    logic [CW-1:0] r_vt, n_vt, r_pfv, n_pfv, r_pt, n_pt;
    logic          r_stop, n_stop, r_fail, n_fail;

    t_bundle bnd;

    always_comb begin
        logic [31:0] part;
        logic [31:0] v;
        logic [2:0]  id;
        logic [28:0] count;
        logic [1:0]  cnt;
        logic        bad;
        t_out        res [N_SLOTS];

        n_accum = r_accum; n_len = r_len; n_phase = r_phase; n_pairs = r_pairs;
        n_pdx = r_pdx; n_cx = r_cx; n_cy = r_cy; n_rfx = r_rfx; n_rfy = r_rfy;
        n_vt = r_vt; n_pfv = r_pfv; n_pt = r_pt; n_stop = r_stop; n_fail = r_fail;
        cnt = 2'd0;
        bad = 1'b0;
        v = 32'd0;
        id = v[2:0];
        count = v[31:3];
        for (int i = 0; i < N_SLOTS; i++) res[i] = make_res(KIND_VERTEX, '0, '0, '0, '0);

        unique case (r_len[2:0])
            3'd0:    part = {25'd0, i_data.byte_value[6:0]};
            3'd1:    part = {18'd0, i_data.byte_value[6:0], 7'd0};
            3'd2:    part = {11'd0, i_data.byte_value[6:0], 14'd0};
            3'd3:    part = {4'd0, i_data.byte_value[6:0], 21'd0};
            3'd4:    part = {i_data.byte_value[3:0], 28'd0};
            default: part = 32'd0;
        endcase

        if (!r_stop && !r_fail) begin
            if (r_len < VARINT_KEEP) n_accum = r_accum | part;
            n_len = r_len + 4'd1;
            if (!i_data.byte_value[7]) begin
                v = n_accum;
                n_accum = 32'd0;
                n_len = 4'd0;
                id = v[2:0];
                count = v[31:3];
                unique case (r_phase)
                    PH_CMD: begin
                        if (id == CMD_MOVE_TO || id == CMD_LINE_TO) begin
                            if (id == CMD_MOVE_TO && r_vt > r_pfv) begin
                                n_pt = r_pt + 1'b1;
                                n_pfv = r_vt;
                                res[cnt] = make_res(KIND_PART_END, '0, '0,
                                                    idx16(r_vt), idx16(n_pt));
                                cnt = cnt + 2'd1;
                            end
                            n_pairs = count;
                            n_phase = (count != 29'd0) ? PH_DX : PH_CMD;
                        end else if (id == CMD_CLOSE_PATH) begin
                            if (r_vt > r_pfv) begin
                                if (r_vt >= MAX_V) begin
                                    n_fail = 1'b1;
                                end else begin
                                    res[cnt] = make_res(KIND_VERTEX, r_rfx, r_rfy,
                                                        idx16(r_vt), idx16(r_pt));
                                    cnt = cnt + 2'd1;
                                    n_vt = r_vt + 1'b1;
                                    n_pt = r_pt + 1'b1;
                                    n_pfv = n_vt;
                                    res[cnt] = make_res(KIND_PART_END, '0, '0,
                                                        idx16(n_vt), idx16(n_pt));
                                    cnt = cnt + 2'd1;
                                end
                            end
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                    PH_DX: begin
                        n_pdx = v;
                        n_phase = PH_DY;
                    end
                    PH_DY: begin
                        n_cx = r_cx + unzig(r_pdx);
                        n_cy = r_cy + unzig(v);
                        if (r_vt >= MAX_V) begin
                            n_fail = 1'b1;
                        end else begin
                            if (r_vt == r_pfv) begin
                                n_rfx = n_cx;
                                n_rfy = n_cy;
                            end
                            res[cnt] = make_res(KIND_VERTEX, n_cx, n_cy,
                                                idx16(r_vt), idx16(r_pt));
                            cnt = cnt + 2'd1;
                            n_vt = r_vt + 1'b1;
                            n_pairs = r_pairs - 29'd1;
                            n_phase = (n_pairs != 29'd0) ? PH_DX : PH_CMD;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end else if (n_len >= VARINT_MAX_LEN) begin
                n_fail = 1'b1;
            end
        end

        if (i_data.end_of_geometry) begin
            bad = n_fail || (!n_stop && (n_len != 4'd0 || n_phase != PH_CMD));
            if (bad) begin
                res[cnt] = make_res(KIND_MALFORMED, '0, '0, '0, '0);
                cnt = cnt + 2'd1;
            end else if (n_vt > n_pfv) begin
                res[cnt] = make_res(KIND_PART_END, '0, '0,
                                    idx16(n_vt), idx16(n_pt + 1'b1));
                cnt = cnt + 2'd1;
                res[cnt] = make_res(KIND_DONE, '0, '0,
                                    idx16(n_vt), idx16(n_pt + 1'b1));
                cnt = cnt + 2'd1;
            end else begin
                res[cnt] = make_res(KIND_DONE, '0, '0, idx16(n_vt), idx16(n_pt));
                cnt = cnt + 2'd1;
            end
        end

        if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;

        bnd.cnt = cnt;
        for (int i = 0; i < N_SLOTS; i++) bnd.res[i] = res[i];
    end

    assign o_push   = i_accept && (bnd.cnt != 2'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_data.end_of_geometry)) begin
            r_accum <= '0; r_len <= '0; r_phase <= PH_CMD; r_pairs <= '0;
            r_pdx <= '0; r_cx <= '0; r_cy <= '0; r_rfx <= '0; r_rfy <= '0;
            r_vt <= '0; r_pfv <= '0; r_pt <= '0; r_stop <= 1'b0; r_fail <= 1'b0;
        end else if (i_accept) begin
            r_accum <= n_accum; r_len <= n_len; r_phase <= n_phase;
            r_pairs <= n_pairs; r_pdx <= n_pdx; r_cx <= n_cx; r_cy <= n_cy;
            r_rfx <= n_rfx; r_rfy <= n_rfy; r_vt <= n_vt; r_pfv <= n_pfv;
            r_pt <= n_pt; r_stop <= n_stop; r_fail <= n_fail;
        end
    end

endmodule

/* hdl/vtgd_queue.sv */
module vtgd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vtgd_pkg::t_bundle   i_bundle,
    input  logic                i_pop,
    output vtgd_pkg::t_bundle   o_head,
    output vtgd_pkg::t_q_status o_status
);
    import vtgd_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    t_bundle         r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_status.full  = (r_cnt == CNTW'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_head         = r_mem[r_rp];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= bump(r_wp);
            if (do_pop) r_rp <= bump(r_rp);
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* hdl/vtgd_back.sv */
module vtgd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vtgd_pkg::t_bundle   i_head,
    input  vtgd_pkg::t_q_status i_status,
    output logic                o_q_pop,
    output vtgd_pkg::t_out      o_data,
    output logic                o_empty,
    input  logic                i_pop
);
    import vtgd_pkg::*;

    logic [1:0] r_k;
    t_out       r_out;
    logic       r_valid;
    logic       load, last_slot;

    assign load      = !i_status.empty && (!r_valid || i_pop);
    assign last_slot = (r_k == i_head.cnt - 2'd1);
    assign o_q_pop   = load && last_slot;
    assign o_data    = r_out;
    assign o_empty   = !r_valid;

    always_ff @(posedge i_clk) begin
        if (load) r_out <= i_head.res[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= last_slot ? 2'd0 : r_k + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* hdl/vector_tile_geometry_decoder_unit.sv */
// channel   direction  handshake            payload
// -------   ---------  -------------------  ------------------------------------------
// input     in         push / full          i_data: byte_value, end_of_geometry
// result    out        empty / pop          o_data: kind, x, y, vertex_index,
//                                             part_index, last_of_run
//
// the front takes one byte per cycle while full is low and decodes it in that cycle
// its results enter the queue at the accept edge; the first is then loaded into the output
// register once the back is free and the rest follow one per cycle while pop is high
// a byte makes 0 to 3 results; one byte per cycle while each makes one and pop is high
// reset is synchronous, active low: decoder state, queue pointers and output valid clear
// a stalled output fills the two-entry queue, then full rises and holds the input
module vector_tile_geometry_decoder_unit #(
    parameter int MAX_VERTICES = vtgd_pkg::MAX_VERTICES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  vtgd_pkg::t_in  i_data,
    output logic           empty,
    input  logic           pop,
    output vtgd_pkg::t_out o_data
);
    import vtgd_pkg::*;

    // front to queue
    logic      f_push;
    t_bundle   f_bundle;
    // queue to back
    t_bundle   q_head;
    t_q_status q_status;
    logic      b_q_pop;
    logic      accept;

    // a byte is taken whenever the queue has room, even while results wait
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // front: varint assembly, command decode, cursors and counters, all in
    // the accept cycle; bytes that cause no result are not queued
    vtgd_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data),
        .o_push   (f_push),
        .o_bundle (f_bundle)
    );

    // short queue of result bundles so front and back stall on their own
    vtgd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_bundle (f_bundle),
        .i_pop    (b_q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // back: walks the slots of the head bundle into a registered output
    vtgd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_status (q_status),
        .o_q_pop  (b_q_pop),
        .o_data   (o_data),
        .o_empty  (empty),
        .i_pop    (pop)
    );

endmodule

/* hdl/vtgd_checker.sv */
module vtgd_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           push,
    input logic           full,
    input vtgd_pkg::t_in  i_data,
    input logic           empty,
    input logic           pop,
    input vtgd_pkg::t_out o_data
);
    import vtgd_pkg::*;

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a waiting result stays put until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data)))
        else $error("waiting result changed before pop");

    // done and malformed always close the run of their byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_data.kind == KIND_DONE || o_data.kind == KIND_MALFORMED))
        |-> o_data.last_of_run)
        else $error("end-of-geometry result not marked last");

    // only vertices carry coordinates
    a_zero_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.kind != KIND_VERTEX) |-> (o_data.x == 0 && o_data.y == 0))
        else $error("non-vertex result carries coordinates");

    // malformed carries zero indices
    a_malf_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.kind == KIND_MALFORMED)
        |-> (o_data.vertex_index == 16'd0 && o_data.part_index == 16'd0))
        else $error("malformed result carries indices");

endmodule

bind vector_tile_geometry_decoder_unit vtgd_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .i_data  (i_data),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data)
);

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vtgd_pkg::*;

    // small vertex limit so that long paths run past it
    localparam int MAX_VERT      = 16;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SECT_BYTES    = 127;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 16;
    localparam logic [2:0] CMD_UNKNOWN = 3'd4;

    // one byte waiting to be sent; hold makes the sender wait until all results are in
    typedef struct {
        t_in item;
        bit  hold;
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_data  = '0;
    logic full;
    logic empty;
    t_out o_data;

    // bytes to send and results still owed by the block
    t_pending   byte_q[$];
    t_out       result_q[$];
    logic [7:0] blob[$];

    // idle odds per phase of the run, in percent
    int send_pct[3] = '{25, 88, 0};
    int recv_pct[3] = '{88, 25, 0};
    int send_idle   = 0;
    int recv_idle   = 0;

    int taken_cnt   = 0;
    int popped_cnt  = 0;
    int queued_cnt  = 0;
    int blobs_seen  = 0;
    int stall_cnt   = 0;
    int errors      = 0;
    int kind_seen[4] = '{0, 0, 0, 0};

    // decoder image: varint assembly, command phase, cursors and counters
    logic [31:0] vx_acc;
    int unsigned vx_len;
    t_phase      dec_phase;
    logic [28:0] pairs_owed;
    logic [31:0] held_dx;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic [31:0] ring_x;
    logic [31:0] ring_y;
    int unsigned n_vert;
    int unsigned part_base;
    int unsigned n_parts;
    bit          halted;
    bit          broken;
    int          byte_results;

    always #HALF_PERIOD i_clk = ~i_clk;

    vector_tile_geometry_decoder_unit #(
        .MAX_VERTICES (MAX_VERT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic [31:0] from_zigzag(input logic [31:0] v);
        return (v >> 1) ^ {32{v[0]}};
    endfunction

    function automatic logic [31:0] to_zigzag(input logic [31:0] d);
        return {d[30:0], 1'b0} ^ {32{d[31]}};
    endfunction

    // back to the idle state, also after every end of geometry
    task automatic clear_decoder();
        vx_acc     = '0;
        vx_len     = 0;
        dec_phase  = PH_CMD;
        pairs_owed = '0;
        held_dx    = '0;
        cur_x      = '0;
        cur_y      = '0;
        ring_x     = '0;
        ring_y     = '0;
        n_vert     = 0;
        part_base  = 0;
        n_parts    = 0;
        halted     = 1'b0;
        broken     = 1'b0;
    endtask

    task automatic note_result(input t_kind k, input logic [31:0] x, input logic [31:0] y,
                               input int unsigned vi, input int unsigned pi);
        t_out r;
        r.kind         = k;
        r.x            = x;
        r.y            = y;
        r.vertex_index = vi[15:0];
        r.part_index   = pi[15:0];
        r.last_of_run  = 1'b0;
        result_q.push_back(r);
        byte_results++;
    endtask

    // a vertex past the limit marks the geometry broken and is dropped
    task automatic place_vertex(input logic [31:0] x, input logic [31:0] y, output bit ok);
        if (n_vert >= MAX_VERT) begin
            broken = 1'b1;
            ok     = 1'b0;
        end else begin
            if (n_vert == part_base) begin
                ring_x = x;
                ring_y = y;
            end
            note_result(KIND_VERTEX, x, y, n_vert, n_parts);
            n_vert++;
            ok = 1'b1;
        end
    endtask

    task automatic close_part();
        n_parts++;
        note_result(KIND_PART_END, '0, '0, n_vert, n_parts);
        part_base = n_vert;
    endtask

    task automatic take_value(input logic [31:0] v);
        bit          ok;
        logic [2:0]  id;
        logic [28:0] cnt;
        case (dec_phase)
            PH_CMD: begin
                id  = v[2:0];
                cnt = v[31:3];
                if (id == CMD_MOVE_TO || id == CMD_LINE_TO) begin
                    // a move first ends the open part
                    if (id == CMD_MOVE_TO && n_vert > part_base)
                        close_part();
                    pairs_owed = cnt;
                    if (cnt != 0)
                        dec_phase = PH_DX;
                    else
                        dec_phase = PH_CMD;
                end else if (id == CMD_CLOSE_PATH) begin
                    // repeat the first vertex of the part, nothing if no part is open
                    if (n_vert > part_base) begin
                        place_vertex(ring_x, ring_y, ok);
                        if (ok)
                            close_part();
                    end
                end else begin
                    halted = 1'b1;
                end
            end
            PH_DX: begin
                held_dx   = v;
                dec_phase = PH_DY;
            end
            default: begin
                cur_x = cur_x + from_zigzag(held_dx);
                cur_y = cur_y + from_zigzag(v);
                place_vertex(cur_x, cur_y, ok);
                if (ok) begin
                    pairs_owed = pairs_owed - 29'd1;
                    if (pairs_owed != 0)
                        dec_phase = PH_DX;
                    else
                        dec_phase = PH_CMD;
                end
            end
        endcase
    endtask

    // works out every result that one accepted byte causes
    task automatic decode_byte(input t_in it);
        logic [31:0] v;
        bit          bad;
        t_out        r;
        byte_results = 0;
        if (!halted && !broken) begin
            if (vx_len < VARINT_KEEP)
                vx_acc = vx_acc | ({25'd0, it.byte_value[6:0]} << (7 * vx_len));
            vx_len++;
            if (!it.byte_value[7]) begin
                v      = vx_acc;
                vx_acc = '0;
                vx_len = 0;
                take_value(v);
            end else if (vx_len >= VARINT_MAX_LEN) begin
                broken = 1'b1;
            end
        end
        if (it.end_of_geometry) begin
            bad = broken || (!halted && (vx_len != 0 || dec_phase != PH_CMD));
            if (bad) begin
                note_result(KIND_MALFORMED, '0, '0, 0, 0);
            end else begin
                if (n_vert > part_base)
                    close_part();
                note_result(KIND_DONE, '0, '0, n_vert, n_parts);
            end
            clear_decoder();
        end
        if (byte_results > 0) begin
            r = result_q.pop_back();
            r.last_of_run = 1'b1;
            result_q.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // varint, sometimes padded with continuation bytes up to the longest allowed
    task automatic add_varint(input logic [31:0] v, input bit may_pad);
        int          n;
        int          total;
        logic [31:0] rest;
        logic [7:0]  b;
        n    = 1;
        rest = v >> 7;
        while (rest != 0) begin
            n++;
            rest = rest >> 7;
        end
        total = n;
        if (may_pad && $urandom_range(7) == 0)
            total = $urandom_range(n + 1, VARINT_MAX_LEN);
        for (int i = 0; i < total; i++) begin
            if (i < 4)
                b[6:0] = 7'(v >> (7 * i));
            else if (i == 4)
                b[6:0] = {3'($urandom_range(7)), v[31:28]};   // top bits fall off
            else
                b[6:0] = 7'($urandom_range(127));             // past 32 bits, ignored
            b[7] = (i != total - 1);
            blob.push_back(b);
        end
    endtask

    task automatic put_command(input logic [2:0] id, input logic [28:0] cnt, input bit may_pad);
        add_varint({cnt, id}, may_pad);
    endtask

    function automatic logic [31:0] rand_delta();
        int unsigned r = $urandom_range(9);
        if (r < 6)
            return 32'($urandom_range(16)) - 32'd8;
        if (r < 8)
            return 32'($urandom_range(20000)) - 32'd10000;
        return $urandom;
    endfunction

    task automatic add_command(input bit long_run);
        logic [2:0]  id;
        int unsigned cnt;
        int          r;
        r = $urandom_range(99);
        if (long_run)
            id = $urandom_range(1) ? CMD_LINE_TO : CMD_MOVE_TO;
        else if (r < 40)
            id = CMD_MOVE_TO;
        else if (r < 78)
            id = CMD_LINE_TO;
        else if (r < 93)
            id = CMD_CLOSE_PATH;
        else begin
            do
                id = 3'($urandom_range(7));
            while (id == CMD_MOVE_TO || id == CMD_LINE_TO || id == CMD_CLOSE_PATH);
        end
        if (long_run)
            cnt = $urandom_range(12, 20);
        else if (id != CMD_MOVE_TO && id != CMD_LINE_TO)
            cnt = $urandom_range(3);
        else
            cnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
        put_command(id, 29'(cnt), 1'b1);
        if (id == CMD_MOVE_TO || id == CMD_LINE_TO) begin
            repeat (cnt) begin
                add_varint(to_zigzag(rand_delta()), 1'b1);
                add_varint(to_zigzag(rand_delta()), 1'b1);
            end
        end
    endtask

    // mostly well-formed geometries, the rest cut short, over-long, noise or with a count beyond its pairs
    task automatic make_blob();
        int r;
        int ncmd;
        int k;
        r    = $urandom_range(99);
        ncmd = $urandom_range(1, 4);
        if (r < 85) begin
            for (int c = 0; c < ncmd; c++)
                add_command(r < 8 && c == 0);
        end else if (r < 90) begin
            for (int c = 0; c < ncmd; c++)
                add_command(1'b0);
            k = $urandom_range(1, blob.size());
            while (blob.size() > k)
                void'(blob.pop_back());
        end else if (r < 94) begin
            add_command(1'b0);
            repeat ($urandom_range(10, 12))
                blob.push_back({1'b1, 7'($urandom_range(127))});
            if ($urandom_range(1))
                blob.push_back(8'($urandom_range(127)));
        end else if (r < 97) begin
            repeat ($urandom_range(1, 6))
                blob.push_back(8'($urandom_range(255)));
        end else begin
            // count far beyond the pairs that follow
            put_command(CMD_LINE_TO, 29'($urandom), 1'b1);
            add_varint(to_zigzag(rand_delta()), 1'b1);
            add_varint(to_zigzag(rand_delta()), 1'b1);
        end
    endtask

    // moves the built geometry to the send queue, end marker on its last byte
    task automatic queue_blob(input bit hold);
        t_pending p;
        for (int i = 0; i < blob.size(); i++) begin
            p.item.byte_value      = blob[i];
            p.item.end_of_geometry = (i == blob.size() - 1);
            p.hold                 = hold && (i == 0);
            byte_q.push_back(p);
        end
        queued_cnt += blob.size();
        blob.delete();
    endtask

    task automatic directed_blobs();
        // coordinate extremes, then a close that repeats the first vertex
        put_command(CMD_MOVE_TO, 29'd1, 1'b0);
        add_varint(to_zigzag(32'h7fffffff), 1'b0);
        add_varint(to_zigzag(32'h80000000), 1'b0);
        put_command(CMD_CLOSE_PATH, 29'd1, 1'b0);
        queue_blob(1'b1);
        // zero-count move ends the part, close with no part, unknown id stops decoding
        put_command(CMD_MOVE_TO, 29'd1, 1'b0);
        add_varint('0, 1'b0);
        add_varint('0, 1'b0);
        put_command(CMD_MOVE_TO, 29'd0, 1'b0);
        put_command(CMD_CLOSE_PATH, 29'd1, 1'b0);
        put_command(CMD_UNKNOWN, 29'd0, 1'b0);
        blob.push_back(8'hff);
        queue_blob(1'b0);
        // varint still open at the end
        put_command(CMD_MOVE_TO, 29'd1, 1'b0);
        blob.push_back(8'h80);
        queue_blob(1'b0);
        // pairs still owed at the end
        put_command(CMD_LINE_TO, 29'd1, 1'b0);
        queue_blob(1'b0);
        // tenth byte still continues
        repeat (VARINT_MAX_LEN)
            blob.push_back(8'hff);
        queue_blob(1'b0);
    endtask

    // ------------------------------------------------------------------
    // driver: new input values and pop at the falling edge
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            // the item shown last cycle went in at the rising edge
            if (taken_cnt != popped_cnt) begin
                void'(byte_q.pop_front());
                popped_cnt++;
            end
            if (byte_q.size() != 0 && !(byte_q[0].hold && result_q.size() != 0) &&
                $urandom_range(99) >= send_idle) begin
                push   <= 1'b1;
                i_data <= byte_q[0].item;
            end else begin
                push <= 1'b0;
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        bit   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            // check before predicting, so a result can never meet its own byte
            if (pop && !empty) begin
                moved = 1'b1;
                kind_seen[o_data.kind]++;
                if (result_q.size() == 0) begin
                    $error("result with nothing expected: kind %0d", o_data.kind);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    check_field("kind", want.kind, o_data.kind);
                    check_field("x", want.x, o_data.x);
                    check_field("y", want.y, o_data.y);
                    check_field("vertex_index", want.vertex_index, o_data.vertex_index);
                    check_field("part_index", want.part_index, o_data.part_index);
                    check_field("last_of_run", want.last_of_run, o_data.last_of_run);
                end
            end
            if (push && !full) begin
                moved = 1'b1;
                decode_byte(i_data);
                taken_cnt++;
                if (i_data.end_of_geometry)
                    blobs_seen++;
            end
            // watchdog on cycles with no handshake at all
            if (moved)
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("vector_tile_geometry_decoder_unit: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // run: reset, three idle phases, drain
    // ------------------------------------------------------------------

    initial begin
        bit first;
        clear_decoder();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int sect = 0; sect < 3; sect++) begin
            @(posedge i_clk);
            send_idle  = send_pct[sect];
            recv_idle  = recv_pct[sect];
            queued_cnt = 0;
            first      = 1'b1;
            if (sect == 0) begin
                directed_blobs();
                first = 1'b0;
            end
            while (queued_cnt < SECT_BYTES) begin
                make_blob();
                // sender waits for all results at each phase start and now and then
                queue_blob(first || $urandom_range(19) == 0);
                first = 1'b0;
            end
            while (byte_q.size() != 0)
                @(posedge i_clk);
        end
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $error("%0d results never arrived", result_q.size());
            errors++;
        end
        $display("sent %0d bytes in %0d geometries with vertex limit %0d", taken_cnt,
                 blobs_seen, MAX_VERT);
        $display("results: %0d vertices, %0d part ends, %0d done, %0d malformed",
                 kind_seen[KIND_VERTEX], kind_seen[KIND_PART_END], kind_seen[KIND_DONE],
                 kind_seen[KIND_MALFORMED]);
        if (errors == 0)
            $display("vector_tile_geometry_decoder_unit: match");
        else
            $display("vector_tile_geometry_decoder_unit: mismatch");
        $finish;
    end

endmodule
